[rtl/core/itnl_pkg.sv]
// ============================================================================
// itnl_pkg
// Shared types and constants for the in-order tree neighbor lookup.
// ============================================================================
package itnl_pkg;

    localparam int IN_W   = 16;  // width of the queried id
    localparam int CFG_W  = 16;  // width of the numeric configuration registers
    localparam int ADDR_W = 4;   // register file address width
    localparam int DATA_W = 32;  // register file data width

    typedef enum logic [1:0] {
        REG_FIRST_ID    = 2'd0,
        REG_ID_STEP     = 2'd1,
        REG_NODE_BUDGET = 2'd2,
        REG_ROOT_AT_MIN = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        KIND_ROOT  = 2'd0,
        KIND_INNER = 2'd1,
        KIND_LEAF  = 2'd2
    } node_kind_t;

endpackage

[rtl/core/inorder_tree_neighbor_lookup.sv]
// ============================================================================
// inorder_tree_neighbor_lookup
// Neighbor lookup in an in-order numbered binary tree: recovers the in-order
// position of a node id, then returns parent, children and node kind.
// ============================================================================
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------
//  s_      | in        | s_valid / s_ready  | s_node_id
//  m_      | out       | m_valid / m_ready  | m_valid_res, m_parent_id, m_left_id,
//          |           |                    | m_right_id, m_node_kind
//  apb     | in        | psel/penable/pready| paddr, pwdata, prdata
//
//  one transaction per cycle sustained when m_ready does not stall; stages:
//  input stage, 16 restoring divider stages at one quotient bit each, tree stage,
//  multiply stage, add and range check into the output register
//  aresetn clears all stage valid bits and loads register reset values
//  a stall on m_ready freezes every stage together; s_ready follows it
//
module inorder_tree_neighbor_lookup
    import itnl_pkg::*;
#(
    parameter int MAX_LEVELS = 15,
    parameter int ID_BITS    = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // query channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [IN_W-1:0]       s_node_id,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_valid_res,
    output logic signed [ID_BITS:0] m_parent_id,
    output logic signed [ID_BITS:0] m_left_id,
    output logic signed [ID_BITS:0] m_right_id,
    output logic [1:0]            m_node_kind,
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready
);

    localparam int OW  = ID_BITS + 1;
    localparam int PW  = MAX_LEVELS + 1;
    localparam int HW  = $clog2(MAX_LEVELS + 1);
    localparam int TW  = $clog2(PW);
    localparam int MW  = PW + CFG_W;
    localparam int SW  = MW + 1;
    localparam int CW  = (SW > OW) ? SW : OW;
    localparam int NDS = IN_W;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] first_id_reg;
    logic [CFG_W-1:0] id_step_reg;
    logic [CFG_W-1:0] node_budget_reg;
    logic             root_at_min_reg;
    logic             cfg_wr;
    reg_idx_t         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_id_reg    <= '0;
            id_step_reg     <= CFG_W'(1);
            node_budget_reg <= CFG_W'(2);
            root_at_min_reg <= 1'b1;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_FIRST_ID:    first_id_reg    <= pwdata[CFG_W-1:0];
                REG_ID_STEP:     id_step_reg     <= pwdata[CFG_W-1:0];
                REG_NODE_BUDGET: node_budget_reg <= pwdata[CFG_W-1:0];
                REG_ROOT_AT_MIN: root_at_min_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_FIRST_ID:    prdata = DATA_W'(first_id_reg);
            REG_ID_STEP:     prdata = DATA_W'(id_step_reg);
            REG_NODE_BUDGET: prdata = DATA_W'(node_budget_reg);
            REG_ROOT_AT_MIN: prdata = DATA_W'(root_at_min_reg);
            default:         prdata = '0;
        endcase
    end

    // tree height from the node budget
    logic [HW-1:0] lvl;
    logic [PW-1:0] npos;
    logic [PW-1:0] top_k;
    logic [PW-1:0] off;
    logic [PW-1:0] sub_root;

    always_comb begin
        int lg;
        lg = 0;
        for (int i = 1; i < CFG_W; i++) begin
            if (node_budget_reg[i]) begin
                lg = i;
            end
        end
        if (lg < 1) begin
            lg = 1;
        end
        if (lg > MAX_LEVELS) begin
            lg = MAX_LEVELS;
        end
        lvl = HW'(lg);
    end

    assign npos     = PW'(1) << lvl;
    assign top_k    = root_at_min_reg ? '0 : npos - PW'(1);
    assign off      = root_at_min_reg ? '0 : PW'(1);
    assign sub_root = PW'(1) << (lvl - HW'(1));

    // ------------------------------------------------------------------
    // pipeline control
    // ------------------------------------------------------------------
    logic en;
    logic out_vld_reg;

    assign en      = !out_vld_reg || m_ready;
    assign s_ready = en;

    // ------------------------------------------------------------------
    // input stage and divider stages, index 0 is the input stage
    // ------------------------------------------------------------------
    logic              div_vld_reg [0:NDS];
    logic              div_bad_reg [0:NDS];
    logic [IN_W-1:0]   div_rem_reg [0:NDS];
    logic [IN_W-1:0]   div_dq_reg  [0:NDS];

    logic              in_bad;
    assign in_bad = (id_step_reg == '0)
                 || ((32'(s_node_id) >> ID_BITS) != 32'd0)
                 || (s_node_id < first_id_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_vld_reg[0] <= 1'b0;
        end else if (en) begin
            div_vld_reg[0] <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            div_bad_reg[0] <= in_bad;
            div_rem_reg[0] <= '0;
            div_dq_reg[0]  <= s_node_id - first_id_reg;
        end
    end

    for (genvar g = 0; g < NDS; g++) begin : g_div
        logic [IN_W:0]   trial;
        logic [IN_W:0]   diff;
        logic [IN_W-1:0] rem_next;
        logic            qbit;

        always_comb begin
            trial = {div_rem_reg[g], div_dq_reg[g][IN_W-1]};
            diff  = trial - {1'b0, id_step_reg};
            qbit  = !diff[IN_W];
            rem_next = qbit ? diff[IN_W-1:0] : trial[IN_W-1:0];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                div_vld_reg[g+1] <= 1'b0;
            end else if (en) begin
                div_vld_reg[g+1] <= div_vld_reg[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                div_bad_reg[g+1] <= div_bad_reg[g];
                div_rem_reg[g+1] <= rem_next;
                div_dq_reg[g+1]  <= {div_dq_reg[g][IN_W-2:0], qbit};
            end
        end
    end

    // ------------------------------------------------------------------
    // tree stage: position to neighbor positions
    // ------------------------------------------------------------------
    logic [IN_W-1:0] quo;
    logic [PW-1:0]   k_pos;
    logic [PW-1:0]   p_pos;
    logic [TW-1:0]   tz;
    logic [PW-1:0]   half;
    logic [PW-1:0]   quarter;
    logic [PW-1:0]   par_p;
    logic            hit;

    logic            vres_next;
    logic            has_par_next, has_lft_next, has_rgt_next;
    logic [PW-1:0]   par_next, lft_next, rgt_next;
    node_kind_t      kind_next;

    assign quo   = div_dq_reg[NDS];
    assign k_pos = PW'(quo);
    assign p_pos = k_pos + off;

    always_comb begin
        tz = '0;
        for (int i = PW - 1; i >= 0; i--) begin
            if (p_pos[i]) begin
                tz = TW'(i);
            end
        end
    end

    assign half    = PW'(1) << tz;
    assign quarter = PW'(1) << (tz - TW'(1));
    assign par_p   = ((p_pos >> (int'(tz) + 1)) & PW'(1)) != '0 ? p_pos - half : p_pos + half;
    assign hit     = !div_bad_reg[NDS] && (div_rem_reg[NDS] == '0)
                  && ((quo >> lvl) == '0);

    always_comb begin
        vres_next    = hit;
        has_par_next = 1'b0;
        has_lft_next = 1'b0;
        has_rgt_next = 1'b0;
        par_next     = '0;
        lft_next     = '0;
        rgt_next     = '0;
        kind_next    = KIND_ROOT;
        if (hit) begin
            if (k_pos == top_k) begin
                if (root_at_min_reg) begin
                    has_rgt_next = 1'b1;
                    rgt_next     = sub_root;
                end else begin
                    has_lft_next = 1'b1;
                    lft_next     = sub_root - PW'(1);
                end
            end else begin
                has_par_next = 1'b1;
                if (int'(tz) == int'(lvl) - 1) begin
                    par_next = top_k;
                end else begin
                    par_next = par_p - off;
                end
                if (tz == '0) begin
                    kind_next = KIND_LEAF;
                end else begin
                    kind_next    = KIND_INNER;
                    has_lft_next = 1'b1;
                    has_rgt_next = 1'b1;
                    lft_next     = p_pos - quarter - off;
                    rgt_next     = p_pos + quarter - off;
                end
            end
        end
    end

    logic            tr_vld_reg;
    logic            tr_vres_reg;
    logic            tr_has_par_reg, tr_has_lft_reg, tr_has_rgt_reg;
    logic [PW-1:0]   tr_par_reg, tr_lft_reg, tr_rgt_reg;
    node_kind_t      tr_kind_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tr_vld_reg <= 1'b0;
        end else if (en) begin
            tr_vld_reg <= div_vld_reg[NDS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tr_vres_reg    <= vres_next;
            tr_has_par_reg <= has_par_next;
            tr_has_lft_reg <= has_lft_next;
            tr_has_rgt_reg <= has_rgt_next;
            tr_par_reg     <= par_next;
            tr_lft_reg     <= lft_next;
            tr_rgt_reg     <= rgt_next;
            tr_kind_reg    <= kind_next;
        end
    end

    // ------------------------------------------------------------------
    // multiply stage: position times step
    // ------------------------------------------------------------------
    logic            mu_vld_reg;
    logic            mu_vres_reg;
    logic            mu_has_par_reg, mu_has_lft_reg, mu_has_rgt_reg;
    logic [MW-1:0]   mu_par_reg, mu_lft_reg, mu_rgt_reg;
    node_kind_t      mu_kind_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mu_vld_reg <= 1'b0;
        end else if (en) begin
            mu_vld_reg <= tr_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mu_vres_reg    <= tr_vres_reg;
            mu_has_par_reg <= tr_has_par_reg;
            mu_has_lft_reg <= tr_has_lft_reg;
            mu_has_rgt_reg <= tr_has_rgt_reg;
            mu_par_reg     <= MW'(tr_par_reg) * MW'(id_step_reg);
            mu_lft_reg     <= MW'(tr_lft_reg) * MW'(id_step_reg);
            mu_rgt_reg     <= MW'(tr_rgt_reg) * MW'(id_step_reg);
            mu_kind_reg    <= tr_kind_reg;
        end
    end

    // ------------------------------------------------------------------
    // output stage: add base id, drop ids that do not fit
    // ------------------------------------------------------------------
    function automatic logic [OW-1:0] to_id(input logic has, input logic [MW-1:0] prod,
                                            input logic [CFG_W-1:0] base);
        logic [CW-1:0] sum;
        sum = CW'(SW'(base) + SW'(prod));
        if (!has || ((sum >> ID_BITS) != '0)) begin
            to_id = '1;
        end else begin
            to_id = sum[OW-1:0];
        end
    endfunction

    logic          out_vres_reg;
    logic [OW-1:0] out_par_reg, out_lft_reg, out_rgt_reg;
    node_kind_t    out_kind_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= mu_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_vres_reg <= mu_vres_reg;
            out_par_reg  <= to_id(mu_has_par_reg, mu_par_reg, first_id_reg);
            out_lft_reg  <= to_id(mu_has_lft_reg, mu_lft_reg, first_id_reg);
            out_rgt_reg  <= to_id(mu_has_rgt_reg, mu_rgt_reg, first_id_reg);
            out_kind_reg <= mu_kind_reg;
        end
    end

    assign m_valid     = out_vld_reg;
    assign m_valid_res = out_vres_reg;
    assign m_parent_id = out_par_reg;
    assign m_left_id   = out_lft_reg;
    assign m_right_id  = out_rgt_reg;
    assign m_node_kind = out_kind_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_invalid_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_valid_res |-> m_parent_id == '1 && m_left_id == '1
                                 && m_right_id == '1 && m_node_kind == KIND_ROOT)
        else $error("invalid result carries neighbor ids");

    a_leaf_no_child: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_node_kind == KIND_LEAF |-> m_left_id == '1 && m_right_id == '1)
        else $error("leaf reported with a child");

    a_root_no_parent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_node_kind == KIND_ROOT |-> m_parent_id == '1)
        else $error("top node reported with a parent");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output register");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(tr_vld_reg) && $stable(mu_vld_reg))
        else $error("pipeline moved during output stall");

endmodule
